>>> hw/rtl/tlbpc_pkg.sv
package tlbpc_pkg;

  // Operation carried by one input transaction.
  typedef enum logic [1:0] {
    KindTlbFill    = 2'd0,
    KindPtWrite    = 2'd1,
    KindCacheWrite = 2'd2,
    KindTranslate  = 2'd3
  } kind_e;

  // Virtual address layout: 14 bits, 64-byte pages, 4-byte cache lines.
  localparam int unsigned VaWidth    = 14;
  localparam int unsigned PageBits   = 6;
  localparam int unsigned VpnWidth   = 8;
  localparam int unsigned TagWidth   = 6;
  localparam int unsigned FrameWidth = 6;
  localparam int unsigned IdxWidth   = 4;
  localparam int unsigned OffWidth   = 2;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned LineWidth  = 32;

  typedef struct packed {
    kind_e                 kind;
    logic [IdxWidth-1:0]   set_index;
    logic [TagWidth-1:0]   entry_tag;
    logic [FrameWidth-1:0] page_frame;
    logic [VpnWidth-1:0]   virtual_page;
    logic [ByteWidth-1:0]  line_byte0;
    logic [ByteWidth-1:0]  line_byte1;
    logic [ByteWidth-1:0]  line_byte2;
    logic [ByteWidth-1:0]  line_byte3;
    logic [VaWidth-1:0]    virtual_address;
  } in_item_t;

  typedef struct packed {
    logic                  determined;
    logic                  tlb_hit;
    logic [FrameWidth-1:0] physical_page;
    logic [ByteWidth-1:0]  data_byte;
  } out_item_t;

endpackage

>>> hw/rtl/tlb_page_table_cache_lookup_core.sv
// Address translation core: a set-associative TLB, a page table memory and a
// direct-mapped physical cache that share one input channel. Fill, page table
// and cache line transactions update state and return nothing; a translate
// transaction returns one result carrying the physical page, whether it came
// from the TLB, and the addressed byte when the cache line holds that page.
// After reset the core zeroes the page table memory, one entry per cycle,
// and holds in_stall_o high meanwhile. From then on it accepts one
// transaction every cycle unless stalled: a translate reads the page table
// memory in the cycle it is accepted and waits in the stage register, from
// where the TLB compare, the page table fallback and the cache tag check
// run as one combinational pass into the output register. Input is
// stalled only while a translate waits behind a stalled output register.
module tlb_page_table_cache_lookup_core #(
  parameter int unsigned TLB_SETS     = 4,
  parameter int unsigned TLB_WAYS     = 4,
  parameter int unsigned CACHE_LINES  = 16,
  parameter int unsigned PAGE_ENTRIES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tlbpc_pkg::in_item_t in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tlbpc_pkg::out_item_t out_item_o
);

  localparam int unsigned SetW  = $clog2(TLB_SETS);
  localparam int unsigned LineW = $clog2(CACHE_LINES);
  localparam int unsigned PtW   = $clog2(PAGE_ENTRIES);
  localparam int unsigned VpnEntries = 2 ** tlbpc_pkg::VpnWidth;
  localparam int unsigned IdxEntries = 2 ** tlbpc_pkg::IdxWidth;

  // State arrays. Tags, frames and line data are only looked at behind a
  // valid bit, so they carry no reset.
  logic [TLB_WAYS-1:0]                tlb_valid_q [TLB_SETS];
  logic [tlbpc_pkg::TagWidth-1:0]     tlb_tags_q  [TLB_SETS][TLB_WAYS];
  logic [tlbpc_pkg::FrameWidth-1:0]   tlb_frames_q[TLB_SETS][TLB_WAYS];
  logic [CACHE_LINES-1:0]             cache_valid_q;
  logic [tlbpc_pkg::TagWidth-1:0]     cache_tags_q[CACHE_LINES];
  logic [tlbpc_pkg::LineWidth-1:0]    cache_data_q[CACHE_LINES];
  logic [tlbpc_pkg::FrameWidth-1:0]   pt_mem_q    [PAGE_ENTRIES];

  // Page table clearing sweep after reset.
  logic           clr_busy_q;
  logic [PtW-1:0] clr_addr_q;

  // Translate stage register.
  logic                             s1_valid_q;
  logic [tlbpc_pkg::TagWidth-1:0]   s1_tag_q;
  logic [SetW-1:0]                  s1_set_q;
  logic [LineW-1:0]                 s1_line_q;
  logic [tlbpc_pkg::OffWidth-1:0]   s1_off_q;
  logic                             s1_pt_oor_q;
  logic [tlbpc_pkg::FrameWidth-1:0] pt_rd_q;

  // Output register.
  logic                 out_valid_q;
  tlbpc_pkg::out_item_t out_item_q;

  logic in_acc;
  logic s1_move;

  // The stage register may only hand its translate on when the output
  // register is free or emptying; otherwise later transactions would change
  // the state that the pending translate still has to read.
  assign s1_move    = !out_valid_q || !out_stall_i;
  assign in_stall_o = clr_busy_q || (s1_valid_q && !s1_move);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Constant tables for the set and line selection, which need a modulo by
  // a size that need not be a power of two.
  logic [SetW-1:0]  set_lut [VpnEntries];
  logic [LineW-1:0] line_lut[IdxEntries];

  always_comb begin
    for (int i = 0; i < VpnEntries; i++) begin
      set_lut[i] = SetW'(i % TLB_SETS);
    end
    for (int j = 0; j < IdxEntries; j++) begin
      line_lut[j] = LineW'(j % CACHE_LINES);
    end
  end

  // Fields of the incoming translate.
  logic [tlbpc_pkg::VpnWidth-1:0] in_vpn;
  logic                           in_is_xlate;
  logic                           in_pt_oor;

  assign in_vpn      = in_item_i.virtual_address[tlbpc_pkg::VaWidth-1:tlbpc_pkg::PageBits];
  assign in_is_xlate = (in_item_i.kind == tlbpc_pkg::KindTranslate);
  assign in_pt_oor   = !(32'(in_vpn) < PAGE_ENTRIES);

  // Fill and write decode.
  logic            fill_we;
  logic            fill_found;
  logic [SetW-1:0] fill_set;
  logic [TLB_WAYS-1:0] fill_way_oh;
  logic            cache_we;
  logic [LineW-1:0] cache_widx;
  logic            pt_wr;

  assign fill_set   = SetW'(in_item_i.set_index);
  assign cache_widx = LineW'(in_item_i.set_index);
  assign cache_we   = in_acc && (in_item_i.kind == tlbpc_pkg::KindCacheWrite) &&
                      (32'(in_item_i.set_index) < CACHE_LINES);
  assign pt_wr      = in_acc && (in_item_i.kind == tlbpc_pkg::KindPtWrite) &&
                      (32'(in_item_i.virtual_page) < PAGE_ENTRIES);

  // The lowest free way of the set takes the new entry; a full set drops it.
  always_comb begin
    fill_found  = 1'b0;
    fill_way_oh = '0;
    for (int w = 0; w < TLB_WAYS; w++) begin
      if (!fill_found && !tlb_valid_q[fill_set][w]) begin
        fill_found     = 1'b1;
        fill_way_oh[w] = 1'b1;
      end
    end
  end

  assign fill_we = in_acc && (in_item_i.kind == tlbpc_pkg::KindTlbFill) &&
                   (32'(in_item_i.set_index) < TLB_SETS) && fill_found;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < TLB_SETS; s++) begin
        tlb_valid_q[s] <= '0;
      end
      cache_valid_q <= '0;
    end else begin
      if (fill_we) begin
        tlb_valid_q[fill_set] <= tlb_valid_q[fill_set] | fill_way_oh;
      end
      if (cache_we) begin
        cache_valid_q[cache_widx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill_we) begin
      for (int w = 0; w < TLB_WAYS; w++) begin
        if (fill_way_oh[w]) begin
          tlb_tags_q[fill_set][w]   <= in_item_i.entry_tag;
          tlb_frames_q[fill_set][w] <= in_item_i.page_frame;
        end
      end
    end
    if (cache_we) begin
      cache_tags_q[cache_widx] <= in_item_i.entry_tag;
      cache_data_q[cache_widx] <= {in_item_i.line_byte3, in_item_i.line_byte2,
                                   in_item_i.line_byte1, in_item_i.line_byte0};
    end
  end

  // Page table memory: one write port shared by the clearing sweep and
  // page table writes, one registered read port for translates.
  logic                             pt_we;
  logic [PtW-1:0]                   pt_waddr;
  logic [tlbpc_pkg::FrameWidth-1:0] pt_wdata;
  logic                             pt_re;

  assign pt_we    = clr_busy_q || pt_wr;
  assign pt_waddr = clr_busy_q ? clr_addr_q : PtW'(in_item_i.virtual_page);
  assign pt_wdata = clr_busy_q ? '0 : in_item_i.page_frame;
  assign pt_re    = in_acc && in_is_xlate;

  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      pt_mem_q[pt_waddr] <= pt_wdata;
    end
    if (pt_re) begin
      pt_rd_q <= pt_mem_q[PtW'(in_vpn)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + PtW'(1);
      if (clr_addr_q == PtW'(PAGE_ENTRIES - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Translate stage register.
  logic s1_valid_d;

  always_comb begin
    if (in_acc) begin
      s1_valid_d = in_is_xlate;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pt_re) begin
      s1_tag_q    <= in_item_i.virtual_address[tlbpc_pkg::VaWidth-1:
                                               tlbpc_pkg::VaWidth-tlbpc_pkg::TagWidth];
      s1_set_q    <= set_lut[in_vpn];
      s1_line_q   <= line_lut[in_item_i.virtual_address[tlbpc_pkg::OffWidth +:
                                                        tlbpc_pkg::IdxWidth]];
      s1_off_q    <= in_item_i.virtual_address[tlbpc_pkg::OffWidth-1:0];
      s1_pt_oor_q <= in_pt_oor;
    end
  end

  // TLB compare across the ways of the set, lowest matching way first, then
  // the page table fallback and the cache tag check.
  logic                             hit;
  logic [tlbpc_pkg::FrameWidth-1:0] tlb_ppn;
  logic [tlbpc_pkg::FrameWidth-1:0] ppn;
  logic                             det;
  logic [tlbpc_pkg::LineWidth-1:0]  line_data;
  tlbpc_pkg::out_item_t             res;

  always_comb begin
    hit     = 1'b0;
    tlb_ppn = '0;
    for (int w = 0; w < TLB_WAYS; w++) begin
      if (!hit && tlb_valid_q[s1_set_q][w] && (tlb_tags_q[s1_set_q][w] == s1_tag_q)) begin
        hit     = 1'b1;
        tlb_ppn = tlb_frames_q[s1_set_q][w];
      end
    end
  end

  assign ppn       = hit ? tlb_ppn : (s1_pt_oor_q ? '0 : pt_rd_q);
  assign det       = cache_valid_q[s1_line_q] && (cache_tags_q[s1_line_q] == ppn);
  assign line_data = cache_data_q[s1_line_q];

  always_comb begin
    res.determined    = det;
    res.tlb_hit       = hit;
    res.physical_page = ppn;
    res.data_byte     = det ? line_data[{s1_off_q, 3'b000} +: tlbpc_pkg::ByteWidth] : '0;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && s1_valid_q) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A pending translate behind a stalled output blocks new transactions.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("transaction accepted while a translate is blocked");

  // A translate that moves on shows up at the output in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_move) |=> out_valid_o)
    else $error("translate result lost");

  // An undetermined result carries a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.determined) |-> (out_item_o.data_byte == '0))
    else $error("data byte set on an undetermined result");

  // Nothing is in flight while the page table is being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> (!s1_valid_q && !out_valid_o))
    else $error("translate in flight during page table clearing");

endmodule
